// ===== design/dcem_pkg.sv =====
// dcem_pkg: shared types and constants for the dual channel e-stop monitor
// no dependencies; imported by dual_channel_estop_monitor
package dcem_pkg;

  localparam int COUNT_WIDTH    = 32;
  localparam int DEBOUNCE_WIDTH = 16;
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = DEBOUNCE_WIDTH'(50);

  typedef enum logic [1:0] {
    REG_DUAL_MODE  = 2'd0,
    REG_AUTO_REARM = 2'd1,
    REG_DEBOUNCE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_SAFE      = 3'b001,
    ST_TRIPPED   = 3'b010,
    ST_RESETTING = 3'b100
  } mode_state_t;

  localparam logic [1:0] MODE_SAFE      = 2'd0;
  localparam logic [1:0] MODE_TRIPPED   = 2'd1;
  localparam logic [1:0] MODE_RESETTING = 2'd2;

  typedef enum logic [2:0] {
    OUT_NONE     = 3'd0,
    OUT_ACCEPTED = 3'd1,
    OUT_REFUSED  = 3'd2,
    OUT_REARMED  = 3'd3,
    OUT_FAILED   = 3'd4
  } reset_outcome_t;

  typedef struct packed {
    logic chan_a_level;
    logic chan_b_level;
    logic force_trip;
    logic reset_request;
    logic clear_fault_cmd;
    logic clear_counts_cmd;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             mode_now;
    logic                   fault_code;
    logic [COUNT_WIDTH-1:0] trip_total;
    logic [COUNT_WIDTH-1:0] fault_total;
    logic                   trip_event;
    logic                   fault_event;
    logic [2:0]             reset_outcome;
  } out_item_t;

  function automatic logic [1:0] mode_code(mode_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_TRIPPED:   code = MODE_TRIPPED;
      ST_RESETTING: code = MODE_RESETTING;
      default:      code = MODE_SAFE;
    endcase
    return code;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

// ===== design/dual_channel_estop_monitor.sv =====
// dual_channel_estop_monitor: two-channel emergency stop supervisor, one tick per request
// depends on dcem_pkg for payload structs, state and outcome codes
//
// Each input request is one sampling tick. The block takes a request in every cycle
// in which in_stall is low: the new state and the result are computed in one pass of
// combinational logic from the state registers and the request, and both land in
// the same clock edge, so a result appears in the cycle after its request is taken.
// The result register holds a result while out_stall is high; in_stall is raised only
// while a result is waiting and the output side stalls. Configuration (dual mode, auto
// rearm, debounce ticks) is written via the APB-style port at byte addresses 0, 4, 8;
// the user must write it only with no request in flight; the block does not enforce it.
module dual_channel_estop_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dcem_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dcem_pkg::out_item_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [dcem_pkg::CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  logic [dcem_pkg::CFG_DATA_WIDTH-1:0] cfg_pwdata,
  output logic [dcem_pkg::CFG_DATA_WIDTH-1:0] cfg_prdata,
  output logic                                cfg_pready
);
  import dcem_pkg::*;

  logic                      dual_mode_r;
  logic                      auto_rearm_r;
  logic [DEBOUNCE_WIDTH-1:0] debounce_ticks_r;
  cfg_reg_t                  cfg_idx;
  logic                      cfg_wr;

  mode_state_t               mode_r, mode_nxt;
  logic                      fault_r, fault_nxt;
  logic [COUNT_WIDTH-1:0]    trip_cnt_r, trip_cnt_nxt;
  logic [COUNT_WIDTH-1:0]    fault_cnt_r, fault_cnt_nxt;
  logic [DEBOUNCE_WIDTH-1:0] debounce_r, debounce_nxt;

  logic                      out_valid_r;
  out_item_t                 out_data_r, out_data_nxt;

  logic                      in_take;
  logic                      a_safe, b_safe, both_safe, ch_trip, mismatch;
  logic                      trip_ev, fault_ev;
  reset_outcome_t            outcome;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_DUAL_MODE:  cfg_prdata = CFG_DATA_WIDTH'(dual_mode_r);
      REG_AUTO_REARM: cfg_prdata = CFG_DATA_WIDTH'(auto_rearm_r);
      REG_DEBOUNCE:   cfg_prdata = CFG_DATA_WIDTH'(debounce_ticks_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dual_mode_r      <= 1'b0;
      auto_rearm_r     <= 1'b0;
      debounce_ticks_r <= DEBOUNCE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DUAL_MODE:  dual_mode_r      <= cfg_pwdata[0];
        REG_AUTO_REARM: auto_rearm_r     <= cfg_pwdata[0];
        REG_DEBOUNCE:   debounce_ticks_r <= cfg_pwdata[DEBOUNCE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // one tick of the monitor
  assign a_safe    = in_data.chan_a_level;
  assign b_safe    = in_data.chan_b_level;
  assign both_safe = a_safe && b_safe;
  assign ch_trip   = dual_mode_r ? (!a_safe && !b_safe) : (!a_safe || !b_safe);
  assign mismatch  = dual_mode_r && (a_safe != b_safe);

  always_comb begin
    trip_cnt_nxt  = in_data.clear_counts_cmd ? '0 : trip_cnt_r;
    fault_cnt_nxt = in_data.clear_counts_cmd ? '0 : fault_cnt_r;
    fault_nxt     = in_data.clear_fault_cmd ? 1'b0 : fault_r;
    mode_nxt      = mode_r;
    debounce_nxt  = debounce_r;
    outcome       = OUT_NONE;
    trip_ev       = 1'b0;
    fault_ev      = 1'b0;

    unique case (mode_r)
      ST_RESETTING: begin
        if (debounce_r != '0) begin
          debounce_nxt = debounce_r - DEBOUNCE_WIDTH'(1);
        end else if (both_safe) begin
          mode_nxt  = ST_SAFE;
          fault_nxt = 1'b0;
          outcome   = OUT_REARMED;
        end else begin
          mode_nxt = ST_TRIPPED;
          outcome  = OUT_FAILED;
        end
      end
      default: begin
        if (in_data.reset_request) begin
          if (both_safe) begin
            mode_nxt     = ST_RESETTING;
            debounce_nxt = debounce_ticks_r;
            outcome      = OUT_ACCEPTED;
          end else begin
            outcome = OUT_REFUSED;
          end
        end
      end
    endcase

    if (in_data.force_trip || (ch_trip && mode_nxt == ST_SAFE)) begin
      mode_nxt     = ST_TRIPPED;
      debounce_nxt = '0;
      trip_cnt_nxt = sat_inc(trip_cnt_nxt);
      trip_ev      = 1'b1;
    end else if (!ch_trip && mode_nxt == ST_TRIPPED && auto_rearm_r) begin
      mode_nxt = ST_SAFE;
    end

    if (mismatch) begin
      fault_nxt     = 1'b1;
      fault_cnt_nxt = sat_inc(fault_cnt_nxt);
      fault_ev      = 1'b1;
    end

    out_data_nxt.mode_now      = mode_code(mode_nxt);
    out_data_nxt.fault_code    = fault_nxt;
    out_data_nxt.trip_total    = trip_cnt_nxt;
    out_data_nxt.fault_total   = fault_cnt_nxt;
    out_data_nxt.trip_event    = trip_ev;
    out_data_nxt.fault_event   = fault_ev;
    out_data_nxt.reset_outcome = outcome;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ST_SAFE;
      fault_r     <= 1'b0;
      trip_cnt_r  <= '0;
      fault_cnt_r <= '0;
      debounce_r  <= '0;
    end else if (in_take) begin
      mode_r      <= mode_nxt;
      fault_r     <= fault_nxt;
      trip_cnt_r  <= trip_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      debounce_r  <= debounce_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_force_trips: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.force_trip |=> out_valid && out_data.trip_event
      && out_data.mode_now == MODE_TRIPPED)
    else $error("forced trip did not produce a tripped result");

  a_fault_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault_event |-> out_data.fault_code)
    else $error("fault event without latched fault code");

  a_accept_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reset_outcome == OUT_ACCEPTED |->
      out_data.mode_now == MODE_RESETTING || out_data.trip_event)
    else $error("accepted reset request left monitor outside resetting");

  a_state_sync: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_take) && rst_n && $past(rst_n) |-> out_data.mode_now == mode_code(mode_r)
      && out_data.trip_total == trip_cnt_r)
    else $error("result register disagrees with monitor state");

endmodule
